[sv/assert_macros.svh]
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[sv/esc_pkg.sv]
`timescale 1ns / 1ps

package esc_pkg;

   // Fixed-point format of the complex plane: signed Q7.24 in 32 bits
   localparam int WORD_W = 32;
   localparam int FRAC_W = 24;
   localparam int HALF_W = 12;
   localparam int OPND_W = WORD_W - HALF_W;

   // Pixel mapping: pixel index in Q9.16 minus the screen center
   localparam int PIX_W   = 8;
   localparam int DIFF_W  = 26;
   localparam int STEP_W  = 25;
   localparam int TERM_W  = WORD_W - 8;
   localparam int SPROD_W = DIFF_W + STEP_W + 1;
   // 71.5 * 65536 and 84.5 * 65536
   localparam logic signed [DIFF_W-1:0] X_CENTRE_Q16 = 26'sd4685824;
   localparam logic signed [DIFF_W-1:0] Y_CENTRE_Q16 = 26'sd5537792;

   // Escape when the integer part of |z|^2 is above this
   localparam int ESCAPE_LIMIT = 4;
   localparam logic signed [WORD_W-1:0] ESC_THRESH =
      WORD_W'((ESCAPE_LIMIT + 1) << FRAC_W);

   // Iteration count and color
   localparam int ITER_W = 10;
   localparam int CH_W   = 8;
   localparam logic [CH_W-1:0] CH_MAX = 8'd255;
   localparam int TRI_W  = ITER_W + 2;

   // Color divider: 255 * num / max_iter, two quotient bits per cycle
   localparam int DIV_W      = ITER_W + CH_W;
   localparam int DIV_BPC    = 2;
   localparam int DIV_CYCLES = DIV_W / DIV_BPC;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_JULIA_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_C_REAL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_C_IMAG     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_RE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_IM  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_STEP = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER   = 3'd6;

   localparam logic [STEP_W-1:0] PIXEL_STEP_RESET = 25'd435766;
   localparam logic [ITER_W-1:0] MAX_ITER_RESET   = 10'd20;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
   } esc_req_type;

   typedef struct packed {
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
      logic              escaped;
      logic [ITER_W-1:0] escape_index;
   } esc_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // capture the request
      logic map;       // multiply pixel offsets by the step
      logic init;      // form the point, z0 and c
      logic mul;       // square and cross products of z
      logic step;      // z = z^2 + c
      logic escape;    // record the escape index
      logic color;     // start the gradient dividers
      logic out_load;  // write the result register
   } esc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic esc_hit;
      logic iter_done;
      logic div_busy;
   } esc_sts_type;

endpackage

[sv/esc_div.sv]
`timescale 1ns / 1ps

// Restoring divider, DIV_BPC quotient bits per cycle
module esc_div import esc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [ITER_W-1:0] divisor,
   output logic              busy,
   output logic [DIV_W-1:0]  quotient
);

   logic [ITER_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [ITER_W-1:0]    dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;

   // Quotient bits of this cycle
   always_comb begin
      logic [ITER_W:0] trial;
      logic [ITER_W-1:0] rem_v;
      logic [DIV_W-1:0] quo_v;
      rem_v = rem_ff;
      quo_v = quo_ff;
      for (int k = 0; k < DIV_BPC; k++) begin
         trial = {rem_v, quo_v[DIV_W-1]};
         if (trial >= {1'b0, dsr_ff}) begin
            trial = trial - {1'b0, dsr_ff};
            quo_v = {quo_v[DIV_W-2:0], 1'b1};
         end else begin
            quo_v = {quo_v[DIV_W-2:0], 1'b0};
         end
         rem_v = trial[ITER_W-1:0];
      end
      rem_in  = rem_v;
      quo_in  = quo_v;
      cnt_in  = cnt_ff + 1'b1;
      busy_in = (cnt_ff != DIV_CNT_W'(DIV_CYCLES - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[sv/esc_dp.sv]
`timescale 1ns / 1ps

// Datapath: config registers, pixel mapping, z iteration, gradient, result
module esc_dp import esc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  esc_cmd_type          cmd,
   output esc_sts_type          sts,
   input  esc_req_type          req_data,
   output esc_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   typedef enum logic [1:0] {SEG_LOW, SEG_MID, SEG_HIGH} seg_type;

   logic                julia_mode_ff;
   logic [WORD_W-1:0]   c_real_ff, c_imag_ff, center_re_ff, center_im_ff;
   logic [STEP_W-1:0]   pixel_step_ff;
   logic [ITER_W-1:0]   max_iter_ff;

   logic [PIX_W-1:0]    px_ff, py_ff;
   logic [TERM_W-1:0]   termx_ff, termy_ff, termx_in, termy_in;
   logic [WORD_W-1:0]   zr_ff, zi_ff, cr_ff, chalf_ff;
   logic [WORD_W-1:0]   zr_in, zi_in, cr_in, chalf_in, zr0, zi0;
   logic [WORD_W-1:0]   rr_ff, ii_ff, ri_ff, rr_in, ii_in, ri_in;
   logic [ITER_W-1:0]   count_ff;
   logic                esc_ff;
   logic [ITER_W-1:0]   idx_ff;
   seg_type             seg_ff, seg_in;
   logic [DIV_W-1:0]    div_a, div_b, quo_a, quo_b;
   logic                busy_a, busy_b;
   esc_rsp_type         rsp_ff, rsp_in;

   // Configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         julia_mode_ff <= 1'b0;
         c_real_ff     <= '0;
         c_imag_ff     <= '0;
         center_re_ff  <= '0;
         center_im_ff  <= '0;
         pixel_step_ff <= PIXEL_STEP_RESET;
         max_iter_ff   <= MAX_ITER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_JULIA_MODE: julia_mode_ff <= csr_wdata[0];
            CSR_C_REAL:     c_real_ff     <= csr_wdata;
            CSR_C_IMAG:     c_imag_ff     <= csr_wdata;
            CSR_CENTER_RE:  center_re_ff  <= csr_wdata;
            CSR_CENTER_IM:  center_im_ff  <= csr_wdata;
            CSR_PIXEL_STEP: pixel_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_MAX_ITER:   max_iter_ff   <= csr_wdata[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   // Pixel offset from the screen center times the step, keep t[23:0] of t = p >>> 24
   always_comb begin
      logic signed [DIFF_W-1:0]  dx, dy, step_s;
      logic signed [SPROD_W-1:0] px_prod, py_prod;
      dx      = $signed({2'b00, px_ff, 16'h0000}) - X_CENTRE_Q16;
      dy      = $signed({2'b00, py_ff, 16'h0000}) - Y_CENTRE_Q16;
      step_s  = $signed({1'b0, pixel_step_ff});
      px_prod = dx * step_s;
      py_prod = dy * step_s;
      termx_in = px_prod[FRAC_W +: TERM_W];
      termy_in = py_prod[FRAC_W +: TERM_W];
   end

   // Point, start value and constant by mode
   always_comb begin
      logic [WORD_W-1:0] pre, pim, ci;
      pre = center_re_ff + {termx_ff, 8'h00};
      pim = center_im_ff - {termy_ff, 8'h00};
      if (julia_mode_ff) begin
         zr0   = pre;
         zi0   = pim;
         cr_in = c_real_ff;
         ci    = c_imag_ff;
      end else begin
         zr0   = '0;
         zi0   = '0;
         cr_in = pre;
         ci    = pim;
      end
      chalf_in = {ci[WORD_W-1], ci[WORD_W-1:1]};
   end

   // Products on operands truncated by 12 bits
   always_comb begin
      logic signed [OPND_W-1:0]   ar, ai;
      logic signed [2*OPND_W-1:0] prr, pii, pri;
      ar    = $signed(zr_ff[WORD_W-1:HALF_W]);
      ai    = $signed(zi_ff[WORD_W-1:HALF_W]);
      prr   = ar * ar;
      pii   = ai * ai;
      pri   = ar * ai;
      rr_in = prr[WORD_W-1:0];
      ii_in = pii[WORD_W-1:0];
      ri_in = pri[WORD_W-1:0];
   end

   // Next z from the registered products
   always_comb begin
      logic [WORD_W-1:0] sum_i;
      sum_i = ri_ff + chalf_ff;
      zr_in = rr_ff - ii_ff + cr_ff;
      zi_in = {sum_i[WORD_W-2:0], 1'b0};
   end

   // Iteration registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= req_data.pixel_x;
         py_ff <= req_data.pixel_y;
      end
      if (cmd.map) begin
         termx_ff <= termx_in;
         termy_ff <= termy_in;
      end
      if (cmd.init) begin
         zr_ff    <= zr0;
         zi_ff    <= zi0;
         cr_ff    <= cr_in;
         chalf_ff <= chalf_in;
         count_ff <= '0;
         esc_ff   <= 1'b0;
      end else if (cmd.step) begin
         zr_ff    <= zr_in;
         zi_ff    <= zi_in;
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.mul) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
      if (cmd.escape) begin
         esc_ff <= 1'b1;
         idx_ff <= count_ff - 1'b1;
      end
   end

   // The products of z after count iterations double as its escape test
   always_comb begin
      logic signed [WORD_W-1:0] mag;
      mag           = $signed(rr_ff + ii_ff);
      sts.esc_hit   = (count_ff != '0) && (mag >= ESC_THRESH);
      sts.iter_done = (count_ff == max_iter_ff);
      sts.div_busy  = busy_a || busy_b;
   end

   // Gradient segment and ramp numerators from 3 * index
   always_comb begin
      logic [TRI_W-1:0] t3, q1, q2, q3, na, nb;
      t3 = {2'b00, idx_ff} + {1'b0, idx_ff, 1'b0};
      q1 = {2'b00, max_iter_ff};
      q2 = {1'b0, max_iter_ff, 1'b0};
      q3 = q1 + q2;
      if (t3 < q1) begin
         seg_in = SEG_LOW;
         na     = q1 - t3;
         nb     = '0;
      end else if (t3 < q2) begin
         seg_in = SEG_MID;
         na     = t3 - q1;
         nb     = q2 - t3;
      end else begin
         seg_in = SEG_HIGH;
         na     = t3 - q2;
         nb     = q3 - t3;
      end
      // 255 * n = 256 * n - n
      div_a = {na[ITER_W-1:0], 8'h00} - {8'h00, na[ITER_W-1:0]};
      div_b = {nb[ITER_W-1:0], 8'h00} - {8'h00, nb[ITER_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (cmd.color) begin
         seg_ff <= seg_in;
      end
   end

   esc_div u_div_a (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.color),
      .dividend (div_a),
      .divisor  (max_iter_ff),
      .busy     (busy_a),
      .quotient (quo_a)
   );

   esc_div u_div_b (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.color),
      .dividend (div_b),
      .divisor  (max_iter_ff),
      .busy     (busy_b),
      .quotient (quo_b)
   );

   // Result assembly; a point that stays bounded is black
   always_comb begin
      rsp_in = '0;
      if (esc_ff) begin
         rsp_in.escaped      = 1'b1;
         rsp_in.escape_index = idx_ff;
         case (seg_ff)
            SEG_LOW: begin
               rsp_in.red   = quo_a[CH_W-1:0];
               rsp_in.green = CH_MAX;
               rsp_in.blue  = CH_MAX;
            end
            SEG_MID: begin
               rsp_in.red   = quo_a[CH_W-1:0];
               rsp_in.green = quo_b[CH_W-1:0];
               rsp_in.blue  = CH_MAX;
            end
            default: begin
               rsp_in.red   = CH_MAX;
               rsp_in.green = quo_a[CH_W-1:0];
               rsp_in.blue  = quo_b[CH_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[sv/esc_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sequencer for one pixel: map, iterate, color, hand off
module esc_ctrl import esc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output esc_cmd_type cmd,
   input  esc_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAP, ST_INIT, ST_MUL, ST_ADD, ST_COLOR, ST_WAIT, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (sts.esc_hit) begin
               cmd.escape = 1'b1;
               state_in   = ST_COLOR;
            end else if (sts.iter_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_COLOR: begin
            cmd.color = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_IMP(a_out_no_overwrite, clock, reset, cmd.out_load, out_free)
   `ASSERT_IMP(a_escape_not_step, clock, reset, cmd.escape, !cmd.step && !cmd.out_load)
   `ASSERT_NXT(a_color_starts_div, clock, reset, cmd.color, sts.div_busy)
   `ASSERT_IMP(a_valid_from_load, clock, reset, $rose(rsp_valid_ff), $past(cmd.out_load))

endmodule

[sv/escape_time_fractal_pixel.sv]
`timescale 1ns / 1ps

// Channel    Ports                          Payload
// request    req_valid, req_stall, req_data esc_req_type (pixel_x, pixel_y)
// result     rsp_valid, rsp_stall, rsp_data esc_rsp_type (red .. escape_index)
// config     csr_we, csr_index, csr_wdata   register index 0..6, 32-bit data
//
// One pixel at a time. Each iteration of z = z^2 + c is a product state and an
// add state in the shared product/add loop, plus one final product pass for the
// escape test. A bounded point goes straight to the hand-off; a point that
// escapes first waits on the 2-bit-per-cycle color dividers.
// Synchronous reset restores the register defaults and idles the sequencer.
// A finished result sits in the output register; the next request is taken
// while it waits, and only the hand-off of that next result waits on rsp_stall.
module escape_time_fractal_pixel import esc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  esc_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output esc_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   esc_cmd_type cmd;
   esc_sts_type sts;

   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   esc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb import esc_pkg::*; ();

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int LATENCY_TAIL = 64;
   localparam int SEG_ITEMS    = 39;
   localparam int DEEP_ITEMS   = 12;
   localparam int N_DRILL      = 23;

   // Index 7 has no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   localparam esc_rsp_type BLACK = '0;
   localparam esc_rsp_type WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255,
                                     escaped: 1'b1, escape_index: 10'd0};

   // Register image of the view
   typedef struct {
      logic                     julia_mode;
      logic signed [WORD_W-1:0] c_real;
      logic signed [WORD_W-1:0] c_imag;
      logic signed [WORD_W-1:0] center_re;
      logic signed [WORD_W-1:0] center_im;
      logic [STEP_W-1:0]        pixel_step;
      logic [ITER_W-1:0]        max_iter;
   } view_type;

   typedef struct packed {
      logic [3:0]       setup;
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      logic             known;
      esc_rsp_type      want;
   } drill_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   esc_req_type          req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   esc_rsp_type          rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   view_type    view;
   esc_rsp_type colors_due[$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_requests = 0;
   int          cycle_count = 0;

   // Directed pixels: extremes, black and white cases, overflow and odd steps
   drill_row_type drills [N_DRILL] = '{
      '{4'd0, 8'd0,   8'd0,   1'b0, BLACK},
      '{4'd0, 8'd255, 8'd255, 1'b0, BLACK},
      '{4'd0, 8'd71,  8'd84,  1'b0, BLACK},
      '{4'd0, 8'd72,  8'd85,  1'b0, BLACK},
      '{4'd0, 8'd255, 8'd0,   1'b0, BLACK},
      '{4'd0, 8'd0,   8'd255, 1'b0, BLACK},
      '{4'd1, 8'd0,   8'd255, 1'b1, BLACK},
      '{4'd1, 8'd255, 8'd0,   1'b1, BLACK},
      '{4'd2, 8'd255, 8'd0,   1'b1, BLACK},
      '{4'd2, 8'd128, 8'd128, 1'b1, BLACK},
      '{4'd3, 8'd128, 8'd128, 1'b1, WHITE},
      '{4'd3, 8'd0,   8'd0,   1'b1, WHITE},
      '{4'd4, 8'd17,  8'd200, 1'b1, WHITE},
      '{4'd5, 8'd60,  8'd80,  1'b0, BLACK},
      '{4'd5, 8'd100, 8'd90,  1'b0, BLACK},
      '{4'd5, 8'd200, 8'd30,  1'b0, BLACK},
      '{4'd6, 8'd255, 8'd0,   1'b0, BLACK},
      '{4'd6, 8'd0,   8'd255, 1'b0, BLACK},
      '{4'd7, 8'd100, 8'd100, 1'b1, BLACK},
      '{4'd8, 8'd0,   8'd0,   1'b0, BLACK},
      '{4'd8, 8'd255, 8'd255, 1'b0, BLACK},
      '{4'd9, 8'd1,   8'd254, 1'b0, BLACK},
      '{4'd9, 8'd254, 8'd1,   1'b0, BLACK}
   };

   escape_time_fractal_pixel dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Truncate both operands to Q7.12, keep the low word of the product
   function automatic logic [WORD_W-1:0] trunc_mul(logic signed [WORD_W-1:0] a,
                                                   logic signed [WORD_W-1:0] b);
      longint signed p;
      p = (longint'(a) >>> HALF_W) * (longint'(b) >>> HALF_W);
      return p[WORD_W-1:0];
   endfunction

   // Pixel distance from the screen center, scaled by the step, in Q7.24
   function automatic logic [WORD_W-1:0] pixel_term(logic [PIX_W-1:0] pix,
                                                    logic signed [DIFF_W-1:0] centre,
                                                    logic [STEP_W-1:0] step);
      longint signed d;
      longint signed t;
      d = longint'(pix) * 65536 - longint'(centre);
      t = (d * longint'(step)) >>> FRAC_W;
      return {t[TERM_W-1:0], 8'd0};
   endfunction

   function automatic int gradient(int num, int q);
      int v;
      if (num <= 0 || q <= 0) return 0;
      v = 255 * num / q;
      return (v > 255) ? 255 : v;
   endfunction

   // Expected color of one pixel under the given view
   function automatic esc_rsp_type paint_pixel(esc_req_type px, view_type v);
      logic signed [WORD_W-1:0] pre, pim, zr, zi, cr, ci, chalf, rr, ii, ri, mag;
      int          q, t, idx, i, r, g, b;
      bit          hit;
      esc_rsp_type res;
      pre = v.center_re + pixel_term(px.pixel_x, X_CENTRE_Q16, v.pixel_step);
      pim = v.center_im - pixel_term(px.pixel_y, Y_CENTRE_Q16, v.pixel_step);
      if (v.julia_mode) begin
         zr = pre; zi = pim; cr = v.c_real; ci = v.c_imag;
      end else begin
         zr = '0; zi = '0; cr = pre; ci = pim;
      end
      chalf = ci >>> 1;
      q = int'(v.max_iter);
      hit = 1'b0;
      idx = 0;
      for (i = 0; i < q && !hit; i++) begin
         rr = trunc_mul(zr, zr);
         ii = trunc_mul(zi, zi);
         ri = trunc_mul(zr, zi);
         zr = rr - ii + cr;
         zi = (ri + chalf) << 1;
         mag = trunc_mul(zr, zr) + trunc_mul(zi, zi);
         if (mag >= ESC_THRESH) begin
            hit = 1'b1;
            idx = i;
         end
      end
      res = '0;
      if (hit) begin
         t = 3 * idx;
         if (t < q) begin
            r = gradient(q - t, q); g = 255; b = 255;
         end else if (t < 2 * q) begin
            r = gradient(t - q, q); g = gradient(2 * q - t, q); b = 255;
         end else begin
            r = 255; g = gradient(t - 2 * q, q); b = gradient(3 * q - t, q);
         end
         res.red = r[7:0];
         res.green = g[7:0];
         res.blue = b[7:0];
         res.escaped = 1'b1;
         res.escape_index = idx[ITER_W-1:0];
      end
      return res;
   endfunction

   function automatic view_type preset(int sel);
      view_type v;
      v.julia_mode = 1'b0;
      v.c_real = '0;
      v.c_imag = '0;
      v.center_re = '0;
      v.center_im = '0;
      v.pixel_step = PIXEL_STEP_RESET;
      v.max_iter = MAX_ITER_RESET;
      case (sel)
         1: v.pixel_step = '0;
         2: v.max_iter = '0;
         3: begin
            v.pixel_step = '0;
            v.center_re = 32'sh0300_0000;
         end
         4: begin
            v.julia_mode = 1'b1;
            v.pixel_step = '0;
            v.center_re = 32'sh0300_0000;
         end
         5: begin
            v.julia_mode = 1'b1;
            v.c_real = -32'sd13421773;
            v.c_imag = 32'sd2617245;
            v.max_iter = 10'd64;
         end
         6: begin
            v.julia_mode = 1'b1;
            v.c_real = 32'sh8000_0000;
            v.c_imag = 32'sh7FFF_FFFF;
            v.center_re = 32'sh7FFF_FFFF;
            v.center_im = 32'sh8000_0000;
            v.pixel_step = 25'h100_0000;
            v.max_iter = 10'd1023;
         end
         7: begin
            v.pixel_step = '0;
            v.max_iter = 10'd1023;
         end
         8: begin
            v.center_re = -32'sd12582912;
            v.center_im = 32'sd1677722;
            v.pixel_step = 25'd1;
            v.max_iter = 10'd3;
         end
         9: begin
            v.pixel_step = 25'h1FF_FFFF;
            v.max_iter = 10'd30;
         end
         default: ;
      endcase
      return v;
   endfunction

   // Mostly within +-2.0, sometimes anywhere, sometimes at the word limits
   function automatic logic signed [WORD_W-1:0] rand_coord();
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sd33554432;
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] rand_step();
      case ($urandom_range(7))
         0: return STEP_W'($urandom_range(1, 4096));
         1: case ($urandom_range(2))
               0: return '0;
               1: return 25'h100_0000;
               default: return 25'h1FF_FFFF;
            endcase
         2: return STEP_W'($urandom);
         default: return STEP_W'($urandom_range(16384, 524288));
      endcase
   endfunction

   function automatic view_type random_view();
      view_type v;
      v.julia_mode = 1'($urandom_range(1));
      v.c_real = rand_coord();
      v.c_imag = rand_coord();
      v.center_re = rand_coord();
      v.center_im = rand_coord();
      v.pixel_step = rand_step();
      v.max_iter = ($urandom_range(15) == 0) ? '0 : ITER_W'($urandom_range(1, 48));
      return v;
   endfunction

   // One register write; csr_we stays high for the caller to lower
   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_JULIA_MODE: view.julia_mode = data[0];
         CSR_C_REAL:     view.c_real = data;
         CSR_C_IMAG:     view.c_imag = data;
         CSR_CENTER_RE:  view.center_re = data;
         CSR_CENTER_IM:  view.center_im = data;
         CSR_PIXEL_STEP: view.pixel_step = data[STEP_W-1:0];
         CSR_MAX_ITER:   view.max_iter = data[ITER_W-1:0];
         default: ;
      endcase
   endtask

   // Load a whole view; narrow registers sometimes get junk in the upper bits
   task automatic program_view(view_type nv);
      logic [WORD_W-1:0] upper;
      upper = $urandom_range(1) ? $urandom : '0;
      csr_put(CSR_JULIA_MODE, {upper[WORD_W-1:1], nv.julia_mode});
      csr_put(CSR_C_REAL, nv.c_real);
      csr_put(CSR_C_IMAG, nv.c_imag);
      csr_put(CSR_CENTER_RE, nv.center_re);
      csr_put(CSR_CENTER_IM, nv.center_im);
      csr_put(CSR_PIXEL_STEP, {upper[WORD_W-1:STEP_W], nv.pixel_step});
      csr_put(CSR_MAX_ITER, {upper[WORD_W-1:ITER_W], nv.max_iter});
      csr_put(CSR_UNUSED, $urandom);
      csr_we <= 1'b0;
   endtask

   // Offer one pixel, hold it until the request is taken
   task automatic send_pixel(esc_req_type px, bit known, esc_rsp_type want);
      esc_rsp_type color;
      bit          taken;
      color = known ? want : paint_pixel(px, view);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      colors_due.push_back(color);
   endtask

   task automatic wait_idle();
      while (colors_due.size() != 0) @(posedge clock);
   endtask

   // Result side stall: random, or a long hold-off when one is requested
   initial begin
      int holds_done;
      int hold_left;
      holds_done = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Result checker, sampled mid-cycle so the handshake is settled
   task automatic check_field(string name, logic [ITER_W-1:0] want, logic [ITER_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   initial begin
      esc_rsp_type got;
      esc_rsp_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = rsp_data;
            if (colors_due.size() == 0) begin
               mismatches++;
               $display("%0t: color with no pixel pending, expected none, actual %h",
                        $time, got);
            end else begin
               want = colors_due.pop_front();
               check_field("red", ITER_W'(want.red), ITER_W'(got.red));
               check_field("green", ITER_W'(want.green), ITER_W'(got.green));
               check_field("blue", ITER_W'(want.blue), ITER_W'(got.blue));
               check_field("escaped", ITER_W'(want.escaped), ITER_W'(got.escaped));
               check_field("escape_index", want.escape_index, got.escape_index);
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb failed");
      $finish;
   end

   initial begin
      int          n;
      int          cur;
      int          phase;
      int          seg;
      int          count;
      esc_req_type px;
      view_type    nv;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      view = preset(0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels, grouped by view
      cur = 0;
      for (n = 0; n < N_DRILL; n++) begin
         if (int'(drills[n].setup) != cur) begin
            req_valid <= 1'b0;
            wait_idle();
            cur = int'(drills[n].setup);
            program_view(preset(cur));
         end
         px.pixel_x = drills[n].px;
         px.pixel_y = drills[n].py;
         send_pixel(px, drills[n].known, drills[n].want);
      end
      req_valid <= 1'b0;
      wait_idle();

      // Random views and pixels under each idling mix
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         for (seg = 0; seg < ((phase == 5) ? 1 : 4); seg++) begin
            nv = random_view();
            count = SEG_ITEMS;
            // deep iteration counts are slow, so only a few pixels
            if (phase == 5) begin
               nv.max_iter = ITER_W'($urandom_range(500, 1023));
               count = DEEP_ITEMS;
            end
            program_view(nv);
            // stall the result side long enough to back up the request side
            if (phase == 0 && seg == 0) hold_requests++;
            repeat (count) begin
               px.pixel_x = PIX_W'($urandom);
               px.pixel_y = PIX_W'($urandom);
               send_pixel(px, 1'b0, BLACK);
            end
            req_valid <= 1'b0;
            wait_idle();
         end
      end

      repeat (LATENCY_TAIL) @(posedge clock);
      if (mismatches == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
